// ----- rtl/core/b64d_pkg.sv -----
// b64d_pkg: shared types, constants and the character-to-sextet map of the base64 decoder.
// No dependencies; imported by every module under rtl/core.
package b64d_pkg;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;   // '='
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;   // '+'
    localparam logic [7:0] ZERO_CHAR  = 8'h30;   // '0'
    localparam logic [7:0] UPPER_A    = 8'h41;   // 'A'
    localparam logic [7:0] LOWER_A    = 8'h61;   // 'a'
    localparam logic [7:0] BND_SYMBOL = 8'h30;
    localparam logic [7:0] BND_DIGIT  = 8'h40;
    localparam logic [7:0] BND_UPPER  = 8'h60;
    localparam logic [7:0] OFS_SYMBOL = 8'd62;
    localparam logic [7:0] OFS_DIGIT  = 8'd52;
    localparam logic [7:0] OFS_LOWER  = 8'd26;

    localparam logic [15:0] MAX_BYTES_RST = 16'hFFFF;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Work of one accepted character: up to three decoded bytes.
    typedef struct packed {
        logic [2:0][7:0] bytes;    // bytes[0] goes out first
        logic [1:0]      n_bytes;  // bytes actually emitted (0..3)
        logic            fin;      // character closed the message
        logic [15:0]     base;     // bytes emitted in the message before this item
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Range arithmetic, everything mod 256.
    function automatic logic [7:0] to_sextet(input logic [7:0] c);
        logic [7:0] d;
        begin
            if (c < BND_SYMBOL) begin
                d = c - PLUS_CHAR;
                to_sextet = OFS_SYMBOL + {2'b00, d[7:2]};
            end else if (c < BND_DIGIT) begin
                to_sextet = OFS_DIGIT + (c - ZERO_CHAR);
            end else if (c < BND_UPPER) begin
                to_sextet = c - UPPER_A;
            end else begin
                to_sextet = OFS_LOWER + (c - LOWER_A);
            end
        end
    endfunction

endpackage

// ----- rtl/core/b64d_front.sv -----
// b64d_front: accepts text characters, keeps the group and message state, and turns each
// character into a bundle of decoded bytes. Also holds the byte limit register.
// Depends on b64d_pkg.
module b64d_front import b64d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_tvalid,
    output logic        o_tready,
    input  logic [7:0]  i_tdata,
    input  logic        i_tlast,
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_bundle     o_bundle
);

    logic [2:0][7:0] r_buf, n_buf;
    logic [1:0]      r_fill, n_fill;
    logic [15:0]     r_rem, n_rem;
    logic [15:0]     r_emitted;
    logic            r_stopped;
    logic [15:0]     r_max;

    logic       accept;
    logic       stop0, stop1, is_pad;
    logic [7:0] sx;
    logic [1:0] k, n;

    assign o_cfg_ready = 1'b1;
    assign o_tready    = !i_q_stat.full;
    assign accept      = i_tvalid && o_tready;

    always_comb begin
        sx     = to_sextet(i_tdata);
        is_pad = (i_tdata == PAD_CHAR);
        stop0  = r_stopped || (r_rem == 16'd0);
        stop1  = stop0;
        n_buf  = r_buf;
        n_fill = r_fill;
        k      = 2'd0;
        if (!stop0) begin
            if (is_pad) begin
                k      = (r_fill > 2'd1) ? r_fill - 2'd1 : 2'd0;
                n_fill = 2'd0;
                stop1  = 1'b1;
            end else if (r_fill < 2'd3) begin
                n_buf[r_fill] = sx;
                n_fill        = r_fill + 2'd1;
            end else begin
                n_fill = 2'd0;
                k      = 2'd3;
            end
        end
        // final flush of a partial group
        if (i_tlast && !stop1) begin
            if (n_fill > 2'd1) k = n_fill - 2'd1;
            n_fill = 2'd0;
        end
        n     = (r_rem < {14'd0, k}) ? r_rem[1:0] : k;
        n_rem = r_rem - {14'd0, n};
    end

    always_comb begin
        o_bundle.bytes[0] = {n_buf[0][5:0], 2'b00} | {4'd0, n_buf[1][7:4]};
        o_bundle.bytes[1] = {n_buf[1][3:0], 4'd0}  | {2'd0, n_buf[2][7:2]};
        o_bundle.bytes[2] = {n_buf[2][1:0], 6'd0}  | sx;
        o_bundle.n_bytes  = n;
        o_bundle.fin      = i_tlast;
        o_bundle.base     = r_emitted;
    end

    assign o_push = accept && ((n != 2'd0) || i_tlast);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf     <= '0;
            r_fill    <= 2'd0;
            r_rem     <= MAX_BYTES_RST;
            r_emitted <= 16'd0;
            r_stopped <= 1'b0;
            r_max     <= MAX_BYTES_RST;
        end else begin
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
                if (r_fill == 2'd0 && r_emitted == 16'd0 && !r_stopped) r_rem <= i_cfg_data;
            end
            if (accept) begin
                r_buf <= n_buf;
                if (i_tlast) begin
                    r_fill    <= 2'd0;
                    r_emitted <= 16'd0;
                    r_stopped <= 1'b0;
                    r_rem     <= r_max;
                end else begin
                    r_fill    <= n_fill;
                    r_emitted <= r_emitted + {14'd0, n};
                    r_stopped <= stop1 || (n_rem == 16'd0);
                    r_rem     <= n_rem;
                end
            end
        end
    end

endmodule

// ----- rtl/core/b64d_queue.sv -----
// b64d_queue: short bundle FIFO between front and back, register based.
// Depends on b64d_pkg.
module b64d_queue import b64d_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    input  logic    i_pop,
    output t_bundle o_head,
    output t_q_stat o_stat
);

    t_bundle          r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr, r_rd;
    logic [Q_AW:0]    r_cnt;

    assign o_stat.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/core/b64d_back.sv -----
// b64d_back: walks the head bundle one byte per cycle into the output register,
// unless the output stalls. Depends on b64d_pkg.
module b64d_back import b64d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_bundle     i_head,
    input  t_q_stat     i_q_stat,
    output logic        o_pop,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [23:0] o_tdata,
    output logic        o_tuser,
    output logic        o_tlast
);

    logic [1:0]  r_idx;
    logic        r_valid;
    logic [7:0]  r_byte;
    logic [15:0] r_so_far;
    logic        r_present, r_last;

    logic        load, present, last_item;
    logic [1:0]  cnt;

    assign present   = (i_head.n_bytes != 2'd0);
    assign cnt       = present ? i_head.n_bytes : 2'd1;
    assign last_item = (r_idx == cnt - 2'd1);
    assign load      = !i_q_stat.empty && (!r_valid || i_tready);
    assign o_pop     = load && last_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last_item ? 2'd0 : r_idx + 2'd1;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte    <= present ? i_head.bytes[r_idx] : 8'd0;
            r_so_far  <= present ? i_head.base + 16'(r_idx) + 16'd1 : i_head.base;
            r_present <= present;
            r_last    <= i_head.fin && last_item;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {r_so_far, r_byte};
    assign o_tuser  = r_present;
    assign o_tlast  = r_last;

endmodule

// ----- rtl/core/base64_decoder_top.sv -----
// base64_decoder_top: base64 text to octets, one character in, up to three bytes out.
// Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back.
//
//  channel   dir  handshake                 payload
//  ------    ---  ------------------------  -------------------------------------------
//  s_axis    in   i_s_axis_tvalid/tready    tdata[7:0] text_char, tlast final_char
//  m_axis    out  o_m_axis_tvalid/tready    tdata[7:0] data_byte, [23:8] bytes_so_far,
//                                           tuser byte_present, tlast end_of_message
//  cfg       in   i_cfg_valid/o_cfg_ready   i_cfg_data[15:0] max_output_bytes
//
// One character is accepted per cycle while the 4-entry bundle queue has room; the
// front decodes it in the accept cycle. The back drains one result item per cycle
// while m_axis is ready, so a complete group of four characters (three bytes) keeps
// up with a character per cycle. Its bytes pass the queue, then the output register.
// Reset (synchronous, active low) clears the queue, the group state and sets the byte
// limit to 65535. A stall on the output fills the queue, then drops s_axis tready.
module base64_decoder_top import b64d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,     // max_output_bytes
    // text in
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [7:0] text_char
    input  logic        i_s_axis_tlast,  // final_char
    // bytes out
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // [7:0] data_byte, [23:8] bytes_so_far
    output logic        o_m_axis_tuser,  // byte_present
    output logic        o_m_axis_tlast   // end_of_message
);

    t_bundle push_bundle, head;
    t_q_stat q_stat;
    logic    push, pop;

    // front: decode and message bookkeeping
    b64d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_tvalid    (i_s_axis_tvalid),
        .o_tready    (o_s_axis_tready),
        .i_tdata     (i_s_axis_tdata),
        .i_tlast     (i_s_axis_tlast),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_bundle    (push_bundle)
    );

    // decouples the bursty byte groups from the steady character stream
    b64d_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .i_pop    (pop),
        .o_head   (head),
        .o_stat   (q_stat)
    );

    // back: serializes bundles into result items
    b64d_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (o_m_axis_tuser),
        .o_tlast  (o_m_axis_tlast)
    );

    // an item without a byte only ever closes a message
    a_nobyte_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("byte-less result item not marked end_of_message");

    // byte-less item carries a zero data byte
    a_nobyte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata[7:0] == 8'd0))
        else $error("byte-less result item has nonzero data");

    // input is held off while the queue is full
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !o_s_axis_tready)
        else $error("input ready while bundle queue full");

    // a pop never happens on an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("bundle queue underflow");

endmodule

// ----- tb/tb_base64_decoder_top.sv -----
`timescale 1ns / 1ps
// tb_base64_decoder_top: self-checking bench for the base64 decoder, directed rows then random
// messages, each item checked against an in-bench decoder or a typed row. Depends on b64d_pkg.
module tb_base64_decoder_top;
    import b64d_pkg::*;

    typedef struct packed {
        logic [7:0]  data;
        logic        present;
        logic        last;
        logic [15:0] count;
    } t_byte_item;

    typedef enum logic {ROW_CHAR, ROW_CFG} t_row_kind;

    // One directed row: a character (or a limit write) and, where obvious, its single result.
    typedef struct packed {
        t_row_kind   kind;
        logic [15:0] value;
        logic        fin;
        logic        typed;
        t_byte_item  want;
    } t_stim_row;

    localparam t_byte_item ANY_ITEM     = '0;
    localparam int         DRAIN_CYCLES = 8;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data    = '0;
    logic        s_last    = 1'b0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [23:0] m_data;
    logic        m_user;
    logic        m_last;

    // decoder state as the bench sees it
    logic [7:0]  sextets [0:2] = '{default: 8'h00};
    logic [1:0]  fill       = 2'd0;
    logic [15:0] byte_limit = MAX_BYTES_RST;
    logic [15:0] bytes_left = MAX_BYTES_RST;
    logic [15:0] bytes_out  = 16'd0;
    logic        halted     = 1'b0;

    t_byte_item char_bytes[$];      // results of the character just accepted
    t_byte_item expected_bytes[$];  // results still owed by the block
    int         fault_count = 0;
    int         idle_pct    = 32;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    base64_decoder_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    // Range arithmetic, wraps at 8 bits for bytes outside the alphabet.
    function automatic logic [7:0] sextet_of(input logic [7:0] c);
        logic [7:0] off;
        if (c < BND_SYMBOL) begin
            off = c - PLUS_CHAR;
            return OFS_SYMBOL + {2'b00, off[7:2]};
        end
        if (c < BND_DIGIT) return OFS_DIGIT + (c - ZERO_CHAR);
        if (c < BND_UPPER) return c - UPPER_A;
        return OFS_LOWER + (c - LOWER_A);
    endfunction

    function automatic logic [7:0] lead_byte();
        return {sextets[0][5:0], 2'b00} | (sextets[1] >> 4);
    endfunction

    function automatic logic [7:0] middle_byte();
        return {sextets[1][3:0], 4'b0000} | (sextets[2] >> 2);
    endfunction

    // at most three bytes per character, none once the limit is hit
    task automatic push_decoded(input logic [7:0] b);
        if (halted || bytes_left == 16'd0 || char_bytes.size() >= 3) return;
        bytes_left = bytes_left - 16'd1;
        bytes_out  = bytes_out + 16'd1;
        char_bytes.push_back('{b, 1'b1, 1'b0, bytes_out});
        if (bytes_left == 16'd0) halted = 1'b1;
    endtask

    task automatic flush_partial();
        if (fill > 2'd1) begin
            push_decoded(lead_byte());
            if (fill == 2'd3) push_decoded(middle_byte());
        end
        fill = 2'd0;
    endtask

    task automatic decode_char(input logic [7:0] c, input logic fin);
        logic [7:0] s3;
        char_bytes.delete();
        if (bytes_left == 16'd0) halted = 1'b1;
        if (!halted) begin
            if (c == PAD_CHAR) begin
                flush_partial();
                halted = 1'b1;
            end else if (fill < 2'd3) begin
                sextets[fill] = sextet_of(c);
                fill = fill + 2'd1;
            end else begin
                s3   = sextet_of(c);
                fill = 2'd0;
                push_decoded(lead_byte());
                push_decoded(middle_byte());
                push_decoded({sextets[2][1:0], 6'b000000} | s3);
            end
        end
        if (fin) begin
            if (!halted) flush_partial();
            // a final character always answers, with an empty item if need be
            if (char_bytes.size() == 0)
                char_bytes.push_back('{8'h00, 1'b0, 1'b1, bytes_out});
            else
                char_bytes[char_bytes.size() - 1].last = 1'b1;
            fill       = 2'd0;
            bytes_out  = 16'd0;
            halted     = 1'b0;
            bytes_left = byte_limit;
        end
    endtask

    task automatic send_char(input logic [7:0] c, input logic fin, input logic typed,
                             input t_byte_item want);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        s_last  <= fin;
        do @(posedge clk); while (!s_ready);
        decode_char(c, fin);
        if (typed)
            expected_bytes.push_back(want);
        else
            foreach (char_bytes[k]) expected_bytes.push_back(char_bytes[k]);
    endtask

    // A new limit reloads now only if the message has not started.
    task automatic write_limit(input logic [15:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        byte_limit = v;
        if (fill == 2'd0 && bytes_out == 16'd0 && !halted) bytes_left = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold the sender off until everything owed has come out, then let the pipe settle.
    task automatic drain_results();
        @(negedge clk);
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fault_count++;
        end
    endtask

    always @(negedge clk) begin
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk) begin : byte_check
        t_byte_item want_item;
        if (rst_n && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected output item: tdata 0x%0h tuser %0b tlast %0b",
                       m_data, m_user, m_last);
                fault_count++;
            end else begin
                want_item = expected_bytes.pop_front();
                check_field("data_byte", want_item.data, m_data[7:0]);
                check_field("bytes_so_far", want_item.count, m_data[23:8]);
                check_field("byte_present", want_item.present, m_user);
                check_field("end_of_message", want_item.last, m_last);
            end
        end
    end

    initial begin : stimulus
        t_stim_row   directed_rows [0:28];
        string       alphabet;
        int unsigned phase;
        int unsigned sent;
        int unsigned len;
        int unsigned k;
        int unsigned roll;
        logic [7:0]  c;
        logic [15:0] lim;

        alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

        directed_rows = '{
            // lone 'A' as the final character: nothing to flush
            '{ROW_CHAR, 16'h0041, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 16'd0}},
            // "+/09": symbol and digit range edges
            '{ROW_CHAR, 16'h002B, 1'b0, 1'b0, ANY_ITEM},
            '{ROW_CHAR, 16'h002F, 1'b0, 1'b0, ANY_ITEM},
            '{ROW_CHAR, 16'h0030, 1'b0, 1'b0, ANY_ITEM},
            '{ROW_CHAR, 16'h0039, 1'b0, 1'b0, ANY_ITEM},
            // 'A', 'z', then 0x00 and 0xFF from outside the alphabet
            '{ROW_CHAR, 16'h0041, 1'b0, 1'b0, ANY_ITEM},
            '{ROW_CHAR, 16'h007A, 1'b0, 1'b0, ANY_ITEM},
            '{ROW_CHAR, 16'h0000, 1'b0, 1'b0, ANY_ITEM},
            '{ROW_CHAR, 16'h00FF, 1'b0, 1'b0, ANY_ITEM},
            // "Za=" pads out one byte; 'x' after the pad is dropped
            '{ROW_CHAR, 16'h005A, 1'b0, 1'b0, ANY_ITEM},
            '{ROW_CHAR, 16'h0061, 1'b0, 1'b0, ANY_ITEM},
            '{ROW_CHAR, 16'h003D, 1'b0, 1'b0, ANY_ITEM},
            '{ROW_CHAR, 16'h0078, 1'b0, 1'b0, ANY_ITEM},
            // final after the pad decodes nothing, reports 7 bytes
            '{ROW_CHAR, 16'h0051, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 16'd7}},
            // "QQQ" final: third char decoded, then two bytes flushed
            '{ROW_CHAR, 16'h0051, 1'b0, 1'b0, ANY_ITEM},
            '{ROW_CHAR, 16'h0051, 1'b0, 1'b0, ANY_ITEM},
            '{ROW_CHAR, 16'h0051, 1'b1, 1'b0, ANY_ITEM},
            // zero limit: final yields only the empty item
            '{ROW_CFG,  16'h0000, 1'b0, 1'b0, ANY_ITEM},
            '{ROW_CHAR, 16'h0041, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 16'd0}},
            // limit of one stops in the middle of a group
            '{ROW_CFG,  16'h0001, 1'b0, 1'b0, ANY_ITEM},
            '{ROW_CHAR, 16'h002B, 1'b0, 1'b0, ANY_ITEM},
            '{ROW_CHAR, 16'h002B, 1'b0, 1'b0, ANY_ITEM},
            '{ROW_CHAR, 16'h002B, 1'b0, 1'b0, ANY_ITEM},
            '{ROW_CHAR, 16'h002B, 1'b1, 1'b0, ANY_ITEM},
            // limit raised mid message: only the next message sees it
            '{ROW_CHAR, 16'h0054, 1'b0, 1'b0, ANY_ITEM},
            '{ROW_CHAR, 16'h0057, 1'b0, 1'b0, ANY_ITEM},
            '{ROW_CFG,  16'hFFFF, 1'b0, 1'b0, ANY_ITEM},
            '{ROW_CHAR, 16'h0046, 1'b0, 1'b0, ANY_ITEM},
            '{ROW_CHAR, 16'h0075, 1'b1, 1'b0, ANY_ITEM}
        };

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                drain_results();
                write_limit(directed_rows[i].value);
            end else begin
                send_char(directed_rows[i].value[7:0], directed_rows[i].fin,
                          directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Random messages, one limit per phase; phase 3 runs with no idling on either side.
        for (phase = 0; phase < 6; phase++) begin
            drain_results();
            case (phase)
                0, 3:    lim = MAX_BYTES_RST;
                1:       lim = 16'd0;
                2:       lim = 16'($urandom_range(8, 1));
                4:       lim = 16'($urandom_range(65535));
                default: lim = 16'($urandom_range(24, 1));
            endcase
            write_limit(lim);
            idle_pct = (phase == 3) ? 0 : 32;
            sent = 0;
            while (sent < 13) begin
                len = $urandom_range(12, 1);
                for (k = 0; k < len; k++) begin
                    roll = $urandom_range(99);
                    if (roll < 10)
                        c = 8'($urandom_range(255));
                    else if (roll < 17)
                        c = PAD_CHAR;
                    else
                        c = alphabet[$urandom_range(63)];
                    send_char(c, (k == len - 1), 1'b0, ANY_ITEM);
                end
                sent += len;
            end
        end

        drain_results();
        if (fault_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end

endmodule
